// ----- sv/cfsf_pkg.sv -----
// shared types, constants and register codes for the complex symmetric fir
// depends on nothing; imported by every module of the block
`default_nettype none

package cfsf_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int COEF_W          = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int SHIFT_W         = 5;
  localparam int COEF_PER_WORD   = 4;
  localparam int NUM_COEF_WORDS  = 3;
  localparam int NUM_LANES       = 2;
  localparam int LANE_RE         = 0;
  localparam int LANE_IM         = 1;
  localparam int HALF_TAPS_DEF   = 12;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(9);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_0 = 2'd0,
    REG_COEF_1 = 2'd1,
    REG_COEF_2 = 2'd2,
    REG_SHIFT  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
  } cfsf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;
  } cfsf_out_t;

endpackage

`default_nettype wire

// ----- sv/cfsf_tap_cell.sv -----
// one tap-pair cell: holds delay entries j and 2*half-1-j for both lanes,
// pre-adds them and multiplies by the cell's coefficient; uses cfsf_pkg
`default_nettype none

module cfsf_tap_cell import cfsf_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     shift_i,
  input  wire logic signed [SB-1:0]     fwd_i [NUM_LANES],
  input  wire logic signed [SB-1:0]     bak_i [NUM_LANES],
  input  wire logic signed [COEF_W-1:0] coef_i,
  output logic signed [SB-1:0]          fwd_o [NUM_LANES],
  output logic signed [SB-1:0]          bak_o [NUM_LANES],
  output logic signed [SB+COEF_W:0]     prod_o [NUM_LANES]
);

  localparam int PRE_W  = SB + 1;
  localparam int PROD_W = SB + COEF_W + 1;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic signed [SB-1:0]     fwd_q, fwd_d, bak_q, bak_d;
    logic signed [PRE_W-1:0]  pre_q, pre_d;
    logic signed [PROD_W-1:0] prod_q, prod_d;

    // delay entries move to the neighbor only when a request is taken
    assign fwd_d  = shift_i ? fwd_i[l] : fwd_q;
    assign bak_d  = shift_i ? bak_i[l] : bak_q;
    assign pre_d  = PRE_W'(fwd_d) + PRE_W'(bak_d);
    assign prod_d = PROD_W'(pre_q) * PROD_W'(coef_i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fwd_q <= '0;
        bak_q <= '0;
      end else begin
        fwd_q <= fwd_d;
        bak_q <= bak_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pre_q  <= pre_d;
        prod_q <= prod_d;
      end
    end

    assign fwd_o[l]  = fwd_q;
    assign bak_o[l]  = bak_q;
    assign prod_o[l] = prod_q;
  end

endmodule

`default_nettype wire

// ----- sv/cfsf_add_tree.sv -----
// registered binary adder tree, one register level per tree level
// uses cfsf_pkg for house conventions only
`default_nettype none

module cfsf_add_tree import cfsf_pkg::*; #(
  parameter int N      = HALF_TAPS_DEF,
  parameter int W_IN   = SAMPLE_BITS_DEF + COEF_W + 1,
  parameter int LEVELS = $clog2(HALF_TAPS_DEF),
  parameter int W_OUT  = SAMPLE_BITS_DEF + COEF_W + 1 + $clog2(HALF_TAPS_DEF)
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [W_IN-1:0]  in_i [N],
  output logic signed [W_OUT-1:0]      sum_o
);

  localparam int PAD = 1 << LEVELS;

  logic signed [W_OUT-1:0] leaf [PAD];
  logic signed [W_OUT-1:0] node_q [1:PAD-1];

  // unused leaves of the padded tree read as zero
  always_comb begin
    for (int i = 0; i < PAD; i++) begin
      leaf[i] = (i < N) ? W_OUT'(in_i[i]) : '0;
    end
  end

  // heap order: node k sums nodes 2k and 2k+1
  for (genvar k = 1; k < PAD; k++) begin : g_node
    if (k >= PAD / 2) begin : g_bottom
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          node_q[k] <= leaf[2*k-PAD] + leaf[2*k-PAD+1];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          node_q[k] <= node_q[2*k] + node_q[2*k+1];
        end
      end
    end
  end

  assign sum_o = node_q[1];

endmodule

`default_nettype wire

// ----- sv/complex_symmetric_fir_24tap_top.sv -----
// top level of the complex symmetric fir: config registers, tap-cell row,
// adder trees, shift/saturate and output skid; uses cfsf_pkg, cfsf_tap_cell,
// cfsf_add_tree
//
//   port group   direction  handshake              payload
//   in_*         in         in_valid_i/in_stall_o  in_data_i  (cfsf_in_t)
//   out_*        out        out_valid_o/out_stall_i out_data_o (cfsf_out_t)
//   cfg_*        in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one request per clock while the skid is empty; a result passes the pre-add, the
// multiply, the adder tree levels and the output register after its request is taken.
// reset clears the delay line, coefficients (zero) and shift (9).
// a stalled result is parked in a one-entry skid; the pipe and the input
// freeze only while that skid is occupied.
`default_nettype none

module complex_symmetric_fir_24tap_top import cfsf_pkg::*; #(
  parameter int HALF_TAPS   = HALF_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire cfsf_in_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output cfsf_out_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SB     = SAMPLE_BITS;
  localparam int H      = HALF_TAPS;
  localparam int PROD_W = SB + COEF_W + 1;
  localparam int LEVELS = $clog2(H);
  localparam int ACC_W  = PROD_W + LEVELS;
  localparam int NSTG   = 2 + LEVELS;

  // ---------------------------------------------------------------- config
  logic [CFG_DATA_W-1:0] coef_word_q [NUM_COEF_WORDS];
  logic [SHIFT_W-1:0]    shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_COEF_WORDS; w++) begin
        coef_word_q[w] <= '0;
      end
      shift_q <= SHIFT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COEF_0: coef_word_q[0] <= cfg_data_i;
        REG_COEF_1: coef_word_q[1] <= cfg_data_i;
        REG_COEF_2: coef_word_q[2] <= cfg_data_i;
        REG_SHIFT:  shift_q        <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------- pipe control
  logic             skid_v_q;
  logic             en;
  logic             accept;
  logic [NSTG-1:0]  vld_q;

  // the whole compute pipe advances unless a result is parked in the skid
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], accept};
    end
  end

  // ---------------------------------------------------------- tap cells
  logic signed [SB-1:0]     x_in   [NUM_LANES];
  logic signed [SB-1:0]     fwd_w  [H][NUM_LANES];
  logic signed [SB-1:0]     bak_w  [H][NUM_LANES];
  logic signed [PROD_W-1:0] prod_w [H][NUM_LANES];
  logic signed [PROD_W-1:0] lane_prod [NUM_LANES][H];

  // only the low sample bits are kept, sign taken from the top kept bit
  assign x_in[LANE_RE] = in_data_i.sample_re[SB-1:0];
  assign x_in[LANE_IM] = in_data_i.sample_im[SB-1:0];

  for (genvar j = 0; j < H; j++) begin : g_cell
    logic signed [SB-1:0]     fwd_in [NUM_LANES];
    logic signed [SB-1:0]     bak_in [NUM_LANES];
    logic signed [COEF_W-1:0] coef;

    assign coef = coef_word_q[j / COEF_PER_WORD][COEF_W*(j % COEF_PER_WORD) +: COEF_W];

    // forward row takes from the left, back row from the right; the last
    // cell folds its own forward entry into the back row
    if (j == 0) begin : g_first
      assign fwd_in = x_in;
    end else begin : g_mid
      assign fwd_in = fwd_w[j-1];
    end
    if (j == H - 1) begin : g_last
      assign bak_in = fwd_w[j];
    end else begin : g_inner
      assign bak_in = bak_w[j+1];
    end

    cfsf_tap_cell #(
      .SB (SB)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (accept),
      .fwd_i   (fwd_in),
      .bak_i   (bak_in),
      .coef_i  (coef),
      .fwd_o   (fwd_w[j]),
      .bak_o   (bak_w[j]),
      .prod_o  (prod_w[j])
    );
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int j = 0; j < H; j++) begin
        lane_prod[l][j] = prod_w[j][l];
      end
    end
  end

  // ---------------------------------------------------------- adder trees
  logic signed [ACC_W-1:0] acc  [NUM_LANES];
  logic signed [ACC_W-1:0] acc_sh [NUM_LANES];
  logic signed [SB-1:0]    sat  [NUM_LANES];
  cfsf_out_t               res;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    cfsf_add_tree #(
      .N      (H),
      .W_IN   (PROD_W),
      .LEVELS (LEVELS),
      .W_OUT  (ACC_W)
    ) u_tree (
      .clk_i (clk_i),
      .en_i  (en),
      .in_i  (lane_prod[l]),
      .sum_o (acc[l])
    );

    // floor shift, then clamp when the bits above the sample sign disagree
    always_comb begin
      acc_sh[l] = acc[l] >>> shift_q;
      if (acc_sh[l][ACC_W-1:SB-1] == '0 || acc_sh[l][ACC_W-1:SB-1] == '1) begin
        sat[l] = acc_sh[l][SB-1:0];
      end else if (acc_sh[l][ACC_W-1]) begin
        sat[l] = {1'b1, {(SB-1){1'b0}}};
      end else begin
        sat[l] = {1'b0, {(SB-1){1'b1}}};
      end
    end
  end

  assign res.out_re = SAMPLE_W'(sat[LANE_RE]);
  assign res.out_im = SAMPLE_W'(sat[LANE_IM]);

  // ------------------------------------------------- output reg and skid
  logic      out_v_q;
  logic      take;
  logic      res_v;
  cfsf_out_t out_q, skid_q;

  assign take  = out_v_q && !out_stall_i;
  assign res_v = en && vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (res_v) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (res_v) begin
      if (!out_v_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------ checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i && vld_q[NSTG-1]))
    else $error("skid filled without a stalled output and a finished result");

  a_out_drop_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_v_q) |-> $past(!out_stall_i))
    else $error("output result vanished without being taken");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> (vld_q == $past(vld_q)))
    else $error("compute pipe moved while the skid was occupied");

endmodule

`default_nettype wire
